### design/largest_prime_exponent_accumulator_top_macros.svh
`ifndef LARGEST_PRIME_EXPONENT_ACCUMULATOR_TOP_MACROS_SVH
`define LARGEST_PRIME_EXPONENT_ACCUMULATOR_TOP_MACROS_SVH

// Assertion helpers that sample on clk and are silent while rst_n is low.
`define LPEA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define LPEA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/lpea_pkg.sv
`timescale 1ns / 1ps

package lpea_pkg;

    localparam int unsigned VALUE_BITS_DEF = 21;
    localparam int unsigned POWER_BITS     = 16;
    localparam int unsigned COUNT_BITS     = 32;
    localparam int unsigned PC_BITS        = 4;

    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_LOAD   = 4'd1,
        OP_DIV    = 4'd2,
        OP_TAKE   = 4'd3,
        OP_NEXTD  = 4'd4,
        OP_FINAL  = 4'd5,
        OP_MUL    = 4'd6,
        OP_UPDATE = 4'd7,
        OP_EMIT   = 4'd8
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER    = 3'd0,
        C_ALWAYS   = 3'd1,
        C_NO_INPUT = 3'd2,
        C_SQ_GT_N  = 3'd3,
        C_DIV_BUSY = 3'd4,
        C_REM_NZ   = 3'd5,
        C_NOT_LAST = 3'd6,
        C_OUT_FULL = 3'd7
    } cond_t;

    typedef struct packed {
        op_t                op;
        cond_t              cond;
        logic [PC_BITS-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic no_input;
        logic sq_gt_n;
        logic div_busy;
        logic rem_nz;
        logic not_last;
        logic out_full;
    } stat_t;

    localparam logic [PC_BITS-1:0] S_IDLE    = 4'd0;
    localparam logic [PC_BITS-1:0] S_TEST    = 4'd1;
    localparam logic [PC_BITS-1:0] S_DSTART  = 4'd2;
    localparam logic [PC_BITS-1:0] S_DWAIT   = 4'd3;
    localparam logic [PC_BITS-1:0] S_REMCHK  = 4'd4;
    localparam logic [PC_BITS-1:0] S_TAKE    = 4'd5;
    localparam logic [PC_BITS-1:0] S_NEXTD   = 4'd6;
    localparam logic [PC_BITS-1:0] S_FINAL   = 4'd7;
    localparam logic [PC_BITS-1:0] S_MUL     = 4'd8;
    localparam logic [PC_BITS-1:0] S_UPD     = 4'd9;
    localparam logic [PC_BITS-1:0] S_LASTCHK = 4'd10;
    localparam logic [PC_BITS-1:0] S_OWAIT   = 4'd11;
    localparam logic [PC_BITS-1:0] S_EMIT    = 4'd12;

    function automatic ctrl_t lpea_ucode(input logic [PC_BITS-1:0] pc);
        ctrl_t w;
        case (pc)
            S_IDLE:    w = '{op: OP_LOAD,   cond: C_NO_INPUT, target: S_IDLE};
            S_TEST:    w = '{op: OP_NONE,   cond: C_SQ_GT_N,  target: S_FINAL};
            S_DSTART:  w = '{op: OP_DIV,    cond: C_NEVER,    target: S_IDLE};
            S_DWAIT:   w = '{op: OP_NONE,   cond: C_DIV_BUSY, target: S_DWAIT};
            S_REMCHK:  w = '{op: OP_NONE,   cond: C_REM_NZ,   target: S_NEXTD};
            S_TAKE:    w = '{op: OP_TAKE,   cond: C_ALWAYS,   target: S_DSTART};
            S_NEXTD:   w = '{op: OP_NEXTD,  cond: C_ALWAYS,   target: S_TEST};
            S_FINAL:   w = '{op: OP_FINAL,  cond: C_NEVER,    target: S_IDLE};
            S_MUL:     w = '{op: OP_MUL,    cond: C_NEVER,    target: S_IDLE};
            S_UPD:     w = '{op: OP_UPDATE, cond: C_NEVER,    target: S_IDLE};
            S_LASTCHK: w = '{op: OP_NONE,   cond: C_NOT_LAST, target: S_IDLE};
            S_OWAIT:   w = '{op: OP_NONE,   cond: C_OUT_FULL, target: S_OWAIT};
            S_EMIT:    w = '{op: OP_EMIT,   cond: C_ALWAYS,   target: S_IDLE};
            default:   w = '{op: OP_NONE,   cond: C_ALWAYS,   target: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

### design/lpea_div.sv
`timescale 1ns / 1ps

module lpea_div #(
    parameter int unsigned W = 21
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder,
    output logic         busy
);

    localparam int unsigned CW = $clog2(W + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  div_reg, div_next;
    logic [W:0]    shifted;
    logic [W:0]    diff;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[W-1]};
        diff     = shifted - {1'b0, div_reg};
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        if (start)
        begin
            cnt_next = CW'(W);
            quo_next = dividend;
            rem_next = '0;
            div_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - CW'(1);
            quo_next = {quo_reg[W-2:0], ~diff[W]};
            rem_next = diff[W] ? shifted[W-1:0] : diff[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign busy      = (cnt_reg != '0);

endmodule

### design/lpea_useq.sv
`timescale 1ns / 1ps

module lpea_useq (
    input  logic            clk,
    input  logic            rst_n,
    input  lpea_pkg::stat_t stat,
    output lpea_pkg::ctrl_t ctrl
);

    import lpea_pkg::*;

    logic [PC_BITS-1:0] pc_reg, pc_next;
    ctrl_t              word;
    logic               jump;

    always_comb
    begin
        word = lpea_ucode(pc_reg);
        case (word.cond)
            C_NEVER:    jump = 1'b0;
            C_ALWAYS:   jump = 1'b1;
            C_NO_INPUT: jump = stat.no_input;
            C_SQ_GT_N:  jump = stat.sq_gt_n;
            C_DIV_BUSY: jump = stat.div_busy;
            C_REM_NZ:   jump = stat.rem_nz;
            C_NOT_LAST: jump = stat.not_last;
            C_OUT_FULL: jump = stat.out_full;
            default:    jump = 1'b1;
        endcase
        pc_next = jump ? word.target : pc_reg + PC_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl = word;

endmodule

### design/lpea_dp.sv
`timescale 1ns / 1ps

module lpea_dp #(
    parameter int unsigned VALUE_BITS = lpea_pkg::VALUE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lpea_pkg::ctrl_t                 ctrl,
    output lpea_pkg::stat_t                 stat,
    input  logic [VALUE_BITS-1:0]           base_value,
    input  logic [lpea_pkg::POWER_BITS-1:0] power,
    input  logic                            group_end,
    input  logic                            in_valid,
    output logic                            in_stall,
    output logic [lpea_pkg::COUNT_BITS-1:0] top_exponent,
    output logic                            out_valid,
    input  logic                            out_stall
);

    import lpea_pkg::*;

    localparam int unsigned VB = VALUE_BITS;
    localparam int unsigned DW = (VB + 1) / 2 + 1;
    localparam int unsigned SQ = VB + 3;
    localparam int unsigned MB = $clog2(VB + 1);
    localparam int unsigned PB = MB + POWER_BITS;

    logic [VB-1:0]         n_reg;
    logic [DW-1:0]         d_reg;
    logic [SQ-1:0]         sq_reg;
    logic [VB-1:0]         p_reg;
    logic [MB-1:0]         m_reg;
    logic [POWER_BITS-1:0] pw_reg;
    logic                  last_reg;
    logic [PB-1:0]         prod_reg;
    logic [VB-1:0]         best_p_reg;
    logic [COUNT_BITS-1:0] best_c_reg;
    logic                  seen_reg;
    logic [COUNT_BITS-1:0] out_reg;
    logic                  out_valid_reg;

    logic [VB-1:0]         d_ext;
    logic [VB-1:0]         quo;
    logic [VB-1:0]         rem;
    logic                  div_busy;
    logic [COUNT_BITS:0]   sum;
    logic [COUNT_BITS-1:0] sum_sat;
    logic                  load;

    lpea_div #(
        .W(VB)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctrl.op == OP_DIV),
        .dividend  (n_reg),
        .divisor   (d_ext),
        .quotient  (quo),
        .remainder (rem),
        .busy      (div_busy)
    );

    always_comb
    begin
        d_ext         = VB'(d_reg);
        load          = (ctrl.op == OP_LOAD) && in_valid;
        sum           = {1'b0, best_c_reg} + (COUNT_BITS + 1)'(prod_reg);
        sum_sat       = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
        stat.no_input = !in_valid;
        stat.sq_gt_n  = sq_reg > SQ'(n_reg);
        stat.div_busy = div_busy;
        stat.rem_nz   = (rem != '0);
        stat.not_last = !last_reg;
        stat.out_full = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            OP_LOAD:
            begin
                if (load)
                begin
                    n_reg    <= base_value;
                    pw_reg   <= power;
                    last_reg <= group_end;
                    d_reg    <= DW'(2);
                    sq_reg   <= SQ'(4);
                    p_reg    <= '0;
                    m_reg    <= '0;
                end
            end
            OP_TAKE:
            begin
                n_reg <= quo;
                if (p_reg == d_ext)
                begin
                    m_reg <= m_reg + MB'(1);
                end
                else
                begin
                    p_reg <= d_ext;
                    m_reg <= MB'(1);
                end
            end
            OP_NEXTD:
            begin
                sq_reg <= sq_reg + SQ'({d_reg, 1'b0}) + SQ'(1);
                d_reg  <= d_reg + DW'(1);
            end
            OP_FINAL:
            begin
                if (n_reg > VB'(1))
                begin
                    if (n_reg == p_reg)
                    begin
                        m_reg <= m_reg + MB'(1);
                    end
                    else
                    begin
                        p_reg <= n_reg;
                        m_reg <= MB'(1);
                    end
                end
            end
            OP_MUL:
            begin
                prod_reg <= PB'(m_reg) * PB'(pw_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_p_reg    <= '0;
            best_c_reg    <= '0;
            seen_reg      <= 1'b0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (ctrl.op)
                OP_UPDATE:
                begin
                    if (p_reg != '0)
                    begin
                        if (!seen_reg || (p_reg > best_p_reg))
                        begin
                            best_p_reg <= p_reg;
                            best_c_reg <= COUNT_BITS'(prod_reg);
                            seen_reg   <= 1'b1;
                        end
                        else if (p_reg == best_p_reg)
                        begin
                            best_c_reg <= sum_sat;
                        end
                    end
                end
                OP_EMIT:
                begin
                    out_reg       <= seen_reg ? best_c_reg : '0;
                    out_valid_reg <= 1'b1;
                    best_p_reg    <= '0;
                    best_c_reg    <= '0;
                    seen_reg      <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign in_stall     = (ctrl.op != OP_LOAD);
    assign top_exponent = out_reg;
    assign out_valid    = out_valid_reg;

endmodule

### design/largest_prime_exponent_accumulator_top.sv
`timescale 1ns / 1ps

// Takes a group of terms (base_value, power) on the input channel, one word per term,
// and returns one word on the output channel for each term with group_end set: the
// total exponent of the largest prime dividing any base_value of the group, saturating at all
// ones, or zero when the group held no prime.
// A word is taken only while in_stall is low; the block takes one term at a time.
// Each term is factored by trial division through one shared radix-2 divider: each
// candidate divisor tried takes one division, and each prime factor removed takes
// one more. Every term then passes the FINAL, MUL and UPD steps; a closing term also
// waits in OWAIT for a free output register, and EMIT then loads its result there.
// The result stays in an output register while out_stall is high, and the next group
// is taken meanwhile; a second result waits until the first one has left.
// Reset clears the group state and the output register.
module largest_prime_exponent_accumulator_top #(
    parameter int unsigned VALUE_BITS = lpea_pkg::VALUE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [VALUE_BITS-1:0]           base_value,
    input  logic [lpea_pkg::POWER_BITS-1:0] power,
    input  logic                            group_end,
    input  logic                            in_valid,
    output logic                            in_stall,
    output logic [lpea_pkg::COUNT_BITS-1:0] top_exponent,
    output logic                            out_valid,
    input  logic                            out_stall
);

    import lpea_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    lpea_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    lpea_dp #(
        .VALUE_BITS(VALUE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .stat         (stat),
        .base_value   (base_value),
        .power        (power),
        .group_end    (group_end),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .top_exponent (top_exponent),
        .out_valid    (out_valid),
        .out_stall    (out_stall)
    );

endmodule

### design/lpea_checker.sv
`timescale 1ns / 1ps

`include "largest_prime_exponent_accumulator_top_macros.svh"

module lpea_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic [lpea_pkg::COUNT_BITS-1:0] top_exponent,
    input logic                            out_valid,
    input logic                            out_stall
);

    `LPEA_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "result word dropped")
    `LPEA_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(top_exponent), "result word changed")
    `LPEA_ASSERT_NXT(a_busy_after_take, in_valid && !in_stall, in_stall, "second word taken at once")
    `LPEA_ASSERT_IMP(a_emit_while_busy, $rose(out_valid), $past(in_stall), "result without term")

endmodule

bind largest_prime_exponent_accumulator_top lpea_checker u_lpea_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .top_exponent (top_exponent),
    .out_valid    (out_valid),
    .out_stall    (out_stall)
);

### tb/lpea_exponent_checker.sv
`timescale 1ns / 1ps

module lpea_exponent_checker #(
    parameter int unsigned VALUE_BITS = lpea_pkg::VALUE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [VALUE_BITS-1:0]           base_value,
    input  logic [lpea_pkg::POWER_BITS-1:0] power,
    input  logic                            group_end,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [lpea_pkg::COUNT_BITS-1:0] top_exponent,
    input  logic                            out_valid,
    input  logic                            out_stall,
    output int                              fail_count,
    output int                              pending
);

    localparam logic [lpea_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [VALUE_BITS-1:0]           lead_prime = '0;
    logic [lpea_pkg::COUNT_BITS-1:0] lead_count = '0;
    logic                            prime_seen = 1'b0;
    logic [lpea_pkg::COUNT_BITS-1:0] exponent_q[$];
    logic [lpea_pkg::COUNT_BITS-1:0] want;
    int                              words_out = 0;

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    function automatic logic [lpea_pkg::COUNT_BITS-1:0] clamp_sum(
        input logic [lpea_pkg::COUNT_BITS-1:0] a,
        input longint unsigned                 b
    );
        longint unsigned s;
        s = 64'(a) + b;
        return (s > 64'(COUNT_MAX)) ? COUNT_MAX : s[lpea_pkg::COUNT_BITS-1:0];
    endfunction

    // Trial division; returns the largest prime factor and how often it divides.
    function automatic void top_factor(
        input  longint unsigned value,
        output longint unsigned prime,
        output longint unsigned mult
    );
        longint unsigned n;
        longint unsigned d;
        longint unsigned k;
        n = value;
        d = 2;
        prime = 0;
        mult = 0;
        while (d * d <= n)
        begin
            if (n % d == 0)
            begin
                k = 0;
                while (n % d == 0)
                begin
                    n = n / d;
                    k++;
                end
                prime = d;
                mult = k;
            end
            d++;
        end
        if (n > 1)
        begin
            if (n == prime)
            begin
                mult++;
            end
            else
            begin
                prime = n;
                mult = 1;
            end
        end
    endfunction

    task automatic absorb_term(
        input logic [VALUE_BITS-1:0]           value,
        input logic [lpea_pkg::POWER_BITS-1:0] pw,
        input logic                            closing
    );
        longint unsigned                 prime;
        longint unsigned                 mult;
        longint unsigned                 add;
        logic [lpea_pkg::COUNT_BITS-1:0] closing_word;
        if (value >= 2)
        begin
            top_factor(64'(value), prime, mult);
            add = mult * 64'(pw);
            if (!prime_seen || prime > 64'(lead_prime))
            begin
                lead_prime = VALUE_BITS'(prime);
                lead_count = clamp_sum('0, add);
                prime_seen = 1'b1;
            end
            else if (prime == 64'(lead_prime))
            begin
                lead_count = clamp_sum(lead_count, add);
            end
        end
        if (closing)
        begin
            closing_word = prime_seen ? lead_count : '0;
            exponent_q = {exponent_q, closing_word};
            lead_prime = '0;
            lead_count = '0;
            prime_seen = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_prime = '0;
            lead_count = '0;
            prime_seen = 1'b0;
            exponent_q.delete();
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (exponent_q.size() == 0)
                begin
                    report_mismatch($sformatf("output word %0d (%0d) arrived with none expected",
                                              words_out, top_exponent));
                end
                else
                begin
                    want = exponent_q.pop_front();
                    if (top_exponent !== want)
                    begin
                        report_mismatch($sformatf("output word %0d: top_exponent %0d, expected %0d",
                                                  words_out, top_exponent, want));
                    end
                end
                words_out++;
            end
            if (in_valid && !in_stall)
            begin
                absorb_term(base_value, power, group_end);
            end
            pending = exponent_q.size();
        end
    end

endmodule

### tb/largest_prime_exponent_accumulator_top_tb.sv
`timescale 1ns / 1ps

module largest_prime_exponent_accumulator_top_tb;

    localparam int unsigned VALUE_BITS   = lpea_pkg::VALUE_BITS_DEF;
    localparam int unsigned VALUE_MAX    = (1 << VALUE_BITS) - 1;
    localparam int unsigned POWER_MAX    = (1 << lpea_pkg::POWER_BITS) - 1;
    localparam int          RANDOM_TERMS = 120;
    localparam int          IDLE_LIMIT   = 200000;
    localparam int          SETTLE       = 64;

    typedef enum int {
        STALL_NONE,
        STALL_HALF,
        STALL_HEAVY
    } stall_mode_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic [VALUE_BITS-1:0]           base_value = VALUE_BITS'(1);
    logic [lpea_pkg::POWER_BITS-1:0] power = '0;
    logic                            group_end = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic [lpea_pkg::COUNT_BITS-1:0] top_exponent;
    logic                            out_valid;
    logic                            out_stall = 1'b0;

    int fail_count;
    int pending;
    int burst_left = 0;
    int terms_sent = 0;
    int idle_cycles = 0;

    largest_prime_exponent_accumulator_top #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .base_value(base_value),
        .power(power),
        .group_end(group_end),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .top_exponent(top_exponent),
        .out_valid(out_valid),
        .out_stall(out_stall)
    );

    lpea_exponent_checker #(
        .VALUE_BITS(VALUE_BITS)
    ) exponent_check (
        .clk(clk),
        .rst_n(rst_n),
        .base_value(base_value),
        .power(power),
        .group_end(group_end),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .top_exponent(top_exponent),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .fail_count(fail_count),
        .pending(pending)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    task automatic send_term(
        input int unsigned value,
        input int unsigned pw,
        input logic        closing
    );
        int gap;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 400) : $urandom_range(1, 12);
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        base_value <= VALUE_BITS'(value);
        power <= lpea_pkg::POWER_BITS'(pw);
        group_end <= closing;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        burst_left--;
        terms_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    function automatic int unsigned pick_value(input int unsigned anchor);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom_range(2, 4096);
            5, 6:          return anchor * $urandom_range(1, 4);
            7:             return 1;
            8:             return $urandom_range(2, 65535);
            default:       return ($urandom_range(0, 2) == 0) ? $urandom_range(1, VALUE_MAX)
                                                              : $urandom_range(2, 4096);
        endcase
    endfunction

    function automatic int unsigned pick_power();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return POWER_MAX;
            2:       return $urandom_range(1, 15);
            default: return $urandom_range(0, POWER_MAX);
        endcase
    endfunction

    initial
    begin
        stall_mode_t mode;
        int left;
        mode = STALL_NONE;
        left = 0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                mode = stall_mode_t'($urandom_range(0, 2));
                left = $urandom_range(100, 3000);
            end
            left--;
            case (mode)
                STALL_NONE: out_stall <= 1'b0;
                STALL_HALF: out_stall <= ($urandom_range(0, 1) == 1);
                default:    out_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int group_len;
        int groups_done;
        int unsigned anchor;
        groups_done = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_term(1, 5, 1'b1);
        send_term(2, POWER_MAX, 1'b1);
        send_term(VALUE_MAX, POWER_MAX, 1'b1);
        send_term(1 << (VALUE_BITS - 1), POWER_MAX, 1'b1);
        send_term(3, 7, 1'b0);
        send_term(5, 0, 1'b0);
        send_term(10, 4, 1'b1);
        send_term(13, 3, 1'b0);
        send_term(12, 9, 1'b0);
        send_term(26, 2, 1'b1);
        send_term(1, 1, 1'b0);
        send_term(1, POWER_MAX, 1'b1);
        send_term(8, 3, 1'b0);
        send_term(4, 5, 1'b0);
        send_term(6, 1, 1'b1);
        send_term(7, 0, 1'b1);
        send_term(VALUE_MAX - 8, 1, 1'b0);
        send_term(1, 0, 1'b1);
        send_term('hAAAA, 'h5555, 1'b0);
        send_term('h5555, 'hAAAA, 1'b1);
        drain_results();

        terms_sent = 0;
        while (terms_sent < RANDOM_TERMS)
        begin
            group_len = $urandom_range(1, 6);
            anchor = $urandom_range(2, 1000);
            for (int i = 0; i < group_len; i++)
            begin
                send_term(pick_value(anchor), pick_power(), i == group_len - 1);
            end
            groups_done++;
            if (groups_done % 12 == 0)
            begin
                drain_results();
            end
        end

        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(negedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
